// ----- design/min_priority_queue_defines.svh -----
// Assertion macros shared by the priority queue RTL.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every clock edge, muted while reset is held
`define MPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, including during reset
`define MPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mpq_pkg.sv -----
// Shared types and codes for the priority queue.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mpq_pkg;

  localparam int STATUS_W = 2;

  // Input action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the input payload
    logic exec;   // apply the held command and write the result register
  } ctl_cmd_t;

endpackage

// ----- design/mpq_if.sv -----
// Handshake channel interfaces for the priority queue.
// Depends on mpq_pkg for the status width.
interface mpq_in_if #(
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [ITEM_BITS-1:0]     in_item;
  logic [PRIORITY_BITS-1:0] in_priority;

  modport source (output valid, action, in_item, in_priority, input ready);
  modport sink   (input valid, action, in_item, in_priority, output ready);
endinterface

interface mpq_out_if #(
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [ITEM_BITS-1:0]           out_item;
  logic [PRIORITY_BITS-1:0]       out_priority;
  logic [mpq_pkg::STATUS_W-1:0]   status;
  logic                           now_empty;

  modport source (output valid, out_item, out_priority, status, now_empty, input ready);
  modport sink   (input valid, out_item, out_priority, status, now_empty, output ready);
endinterface

// ----- design/mpq_ctrl.sv -----
// Sequencer for the priority queue: takes a request, then commits it.
// Depends on mpq_pkg for the command struct.
module mpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mpq_pkg::ctl_cmd_t cmd
);
  import mpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  // Commit only when the result register is free or draining this cycle
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = commit;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on commit, drop on transfer
  always_comb begin
    priority if (commit) out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/mpq_datapath.sv -----
// Sorted entry array with parallel compare-and-shift, fill count and result register.
// Depends on mpq_pkg for codes and the command struct.
module mpq_datapath #(
  parameter int DEPTH         = 16,
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16,
  parameter int CNT_W         = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpq_pkg::ctl_cmd_t              cmd,
  input  logic                           in_action,
  input  logic [ITEM_BITS-1:0]           in_item,
  input  logic [PRIORITY_BITS-1:0]       in_priority,
  output logic [ITEM_BITS-1:0]           out_item,
  output logic [PRIORITY_BITS-1:0]       out_priority,
  output logic [mpq_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_now_empty,
  output logic [CNT_W-1:0]               fill
);
  import mpq_pkg::*;

  logic                     act_r;
  logic [ITEM_BITS-1:0]     item_r;
  logic [PRIORITY_BITS-1:0] pri_r;

  logic [ITEM_BITS-1:0]     slot_item_r   [DEPTH];
  logic [PRIORITY_BITS-1:0] slot_pri_r    [DEPTH];
  logic [ITEM_BITS-1:0]     slot_item_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0] slot_pri_nxt  [DEPTH];
  logic [DEPTH-1:0]         larger;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             is_full, is_empty;
  logic             do_insert, do_remove;

  logic [ITEM_BITS-1:0]     out_item_r;
  logic [PRIORITY_BITS-1:0] out_pri_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_empty_r;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      item_r <= in_item;
      pri_r  <= in_priority;
    end
  end

  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign do_insert = cmd.exec && (act_r == ACT_INSERT) && !is_full;
  assign do_remove = cmd.exec && (act_r == ACT_REMOVE) && !is_empty;

  // Per-slot compare and shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    // Unused slots count as larger so the new entry lands at the tail
    assign larger[i] = (CNT_W'(i) >= count_r) || (pri_r < slot_pri_r[i]);

    always_comb begin
      slot_item_nxt[i] = slot_item_r[i];
      slot_pri_nxt[i]  = slot_pri_r[i];
      if (do_insert && larger[i]) begin
        if (i == 0) begin
          slot_item_nxt[i] = item_r;
          slot_pri_nxt[i]  = pri_r;
        end else if (!larger[(i == 0) ? 0 : i - 1]) begin
          slot_item_nxt[i] = item_r;
          slot_pri_nxt[i]  = pri_r;
        end else begin
          slot_item_nxt[i] = slot_item_r[(i == 0) ? 0 : i - 1];
          slot_pri_nxt[i]  = slot_pri_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_remove && (i < DEPTH - 1)) begin
        slot_item_nxt[i] = slot_item_r[(i < DEPTH - 1) ? i + 1 : i];
        slot_pri_nxt[i]  = slot_pri_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      slot_item_r[i] <= slot_item_nxt[i];
      slot_pri_r[i]  <= slot_pri_nxt[i];
    end
  end

  // Advance the fill count
  always_comb begin
    priority if (do_insert) count_nxt = count_r + CNT_W'(1);
    else if (do_remove)     count_nxt = count_r - CNT_W'(1);
    else                    count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Write the result register on commit
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_item_r   <= '0;
      out_pri_r    <= '0;
      out_status_r <= ST_OK;
      out_empty_r  <= 1'b0;
      if (act_r == ACT_INSERT) begin
        if (is_full) out_status_r <= ST_FULL;
      end else if (is_empty) begin
        out_status_r <= ST_EMPTY;
        out_empty_r  <= 1'b1;
      end else begin
        out_item_r  <= slot_item_r[0];
        out_pri_r   <= slot_pri_r[0];
        out_empty_r <= (count_r == CNT_W'(1));
      end
    end
  end

  assign out_item      = out_item_r;
  assign out_priority  = out_pri_r;
  assign out_status    = out_status_r;
  assign out_now_empty = out_empty_r;
  assign fill          = count_r;

endmodule

// ----- design/min_priority_queue.sv -----
// Bounded min-priority queue kept as a sorted register array, ties in arrival order.
// The request is held in a capture register, then written to the result register on commit.
// The capture/commit sequencer accepts a new request only after the previous one commits;
// the commit waits while an earlier result is still held at the output.
// Reset clears the fill count and handshake state; entries are not cleared.
// Depends on mpq_pkg, mpq_if, mpq_ctrl, mpq_datapath and the defines header.
`include "min_priority_queue_defines.svh"

module min_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int ITEM_BITS     = 32,
  parameter int PRIORITY_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  mpq_in_if.sink    in_if,
  mpq_out_if.source out_if
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  ctl_cmd_t         cmd;
  logic [CNT_W-1:0] fill;
  logic             res_full;
  logic             res_empty;
  logic             fill_top;

  // Sequencer
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // Entry storage and result register
  mpq_datapath #(
    .DEPTH         (DEPTH),
    .ITEM_BITS     (ITEM_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_if.action),
    .in_item       (in_if.in_item),
    .in_priority   (in_if.in_priority),
    .out_item      (out_if.out_item),
    .out_priority  (out_if.out_priority),
    .out_status    (out_if.status),
    .out_now_empty (out_if.now_empty),
    .fill          (fill)
  );

  // Terms for the checks
  assign res_full  = out_if.valid && (out_if.status == ST_FULL);
  assign res_empty = out_if.valid && (out_if.status == ST_EMPTY);
  assign fill_top  = (fill == CNT_W'(DEPTH));

  // Checks
  `MPQ_ASSERT(a_fill_bound, fill <= CNT_W'(DEPTH), "fill count beyond depth")
  `MPQ_ASSERT(a_commit_valid, cmd.exec |=> out_if.valid, "commit without result valid")
  `MPQ_ASSERT(a_empty_flag, res_empty |-> out_if.now_empty, "empty remove not flagged empty")
  `MPQ_ASSERT(a_full_flag, res_full |-> (!out_if.now_empty && fill_top), "full drop inconsistent")

endmodule

// ----- dv/tb_min_priority_queue.sv -----
// Self-checking testbench for min_priority_queue: directed, pressure and random tests.
// Depends on mpq_pkg, the mpq_in_if/mpq_out_if interfaces and the min_priority_queue RTL.
module tb_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int ITEM_W         = 32;
  localparam int PRIO_W         = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ITEM_W-1:0]   item;
    logic [PRIO_W-1:0]   prio;
    logic [STATUS_W-1:0] status;
    logic                empty;
  } pq_result_t;

  logic clk;
  logic rst_n;

  mpq_in_if  #(.ITEM_BITS(ITEM_W), .PRIORITY_BITS(PRIO_W)) in_ch ();
  mpq_out_if #(.ITEM_BITS(ITEM_W), .PRIORITY_BITS(PRIO_W)) out_ch ();

  min_priority_queue #(
    .DEPTH(DEPTH),
    .ITEM_BITS(ITEM_W),
    .PRIORITY_BITS(PRIO_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  // Predicted queue contents, head in slot 0
  logic [ITEM_W-1:0] pq_items [DEPTH];
  logic [PRIO_W-1:0] pq_prios [DEPTH];
  int                pq_count;
  pq_result_t        pending_results [$];

  int  error_count;
  int  quiet_cycles;
  int  hold_cycles;
  bit  bursts_on;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one request to the predicted queue and return the result it yields
  function automatic pq_result_t apply_request(logic act, logic [ITEM_W-1:0] item,
                                               logic [PRIO_W-1:0] prio);
    pq_result_t r;
    int         pos;
    int         k;
    r = '0;
    if (act == ACT_INSERT) begin
      if (pq_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // find the first slot with a strictly larger priority
        pos = 0;
        while (pos < pq_count && !(prio < pq_prios[pos])) pos++;
        for (k = pq_count; k > pos; k--) begin
          pq_items[k] = pq_items[k-1];
          pq_prios[k] = pq_prios[k-1];
        end
        pq_items[pos] = item;
        pq_prios[pos] = prio;
        pq_count++;
        r.status = ST_OK;
      end
    end else if (pq_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.item   = pq_items[0];
      r.prio   = pq_prios[0];
      r.status = ST_OK;
      for (k = 1; k < pq_count; k++) begin
        pq_items[k-1] = pq_items[k];
        pq_prios[k-1] = pq_prios[k];
      end
      pq_count--;
    end
    r.empty = (pq_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ITEM_W-1:0] got,
                                 input logic [ITEM_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Check each result transfer against the oldest prediction, then predict new requests
  always @(posedge clk) begin : check_results
    pq_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_ch.out_item, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.out_item !== want.item)
            report_mismatch("out_item", out_ch.out_item, want.item);
          if (out_ch.out_priority !== want.prio)
            report_mismatch("out_priority", ITEM_W'(out_ch.out_priority),
                            ITEM_W'(want.prio));
          if (out_ch.status !== want.status)
            report_mismatch("status", ITEM_W'(out_ch.status), ITEM_W'(want.status));
          if (out_ch.now_empty !== want.empty)
            report_mismatch("now_empty", ITEM_W'(out_ch.now_empty), ITEM_W'(want.empty));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(apply_request(in_ch.action, in_ch.in_item,
                                                in_ch.in_priority));
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("min_priority_queue verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: long hold-off on request, otherwise random stall bursts
  initial begin : drive_ready
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until the transfer; returns on that rising edge
  task automatic send_request(input logic act, input logic [ITEM_W-1:0] item,
                              input logic [PRIO_W-1:0] prio);
    int gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.in_item     <= item;
    in_ch.in_priority <= prio;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Pause the requests until every prediction has been matched
  task automatic wait_for_results();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Remove on empty, field extremes, ordering by priority
  task automatic test_empty_and_extremes();
    send_request(ACT_REMOVE, '1, '1);
    send_request(ACT_INSERT, '1, '1);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, 32'hA5A5_5A5A, 16'h8000);
    repeat (3) send_request(ACT_REMOVE, $urandom, PRIO_W'($urandom));
    send_request(ACT_REMOVE, '0, '0);
  endtask

  // Equal priorities leave in arrival order
  task automatic test_tie_order();
    send_request(ACT_INSERT, 32'd1, 16'd3);
    send_request(ACT_INSERT, 32'd2, 16'd3);
    send_request(ACT_INSERT, 32'd3, 16'd3);
    send_request(ACT_INSERT, 32'd4, 16'd1);
    send_request(ACT_INSERT, 32'd5, 16'd3);
    repeat (5) send_request(ACT_REMOVE, $urandom, PRIO_W'($urandom));
  endtask

  // Hold results back while inserting past capacity, so the input stalls and drops occur
  task automatic test_fill_under_stall();
    int n;
    wait_for_results();
    hold_cycles = 80;
    for (n = 0; n < DEPTH + 4; n++)
      send_request(ACT_INSERT, $urandom, PRIO_W'($urandom_range(0, 5)));
  endtask

  // Pause until drained, then empty the queue and remove past empty
  task automatic test_pause_and_drain();
    wait_for_results();
    repeat (DEPTH + 2) send_request(ACT_REMOVE, $urandom, PRIO_W'($urandom));
  endtask

  // Random mix, with the insert/remove balance changing between blocks
  task automatic test_random_mix(input int count);
    int                remove_pct;
    int                n;
    logic              act;
    logic [ITEM_W-1:0] item;
    logic [PRIO_W-1:0] prio;
    remove_pct = 50;
    for (n = 0; n < count; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(0, 2))
          0:       remove_pct = 25;
          1:       remove_pct = 50;
          default: remove_pct = 75;
        endcase
      end
      act = ($urandom_range(0, 99) < remove_pct) ? ACT_REMOVE : ACT_INSERT;
      // narrow priorities give many ties
      case ($urandom_range(0, 3))
        0, 1:    prio = PRIO_W'($urandom_range(0, 7));
        2:       prio = PRIO_W'($urandom);
        default: prio = $urandom_range(0, 1) ? '1 : '0;
      endcase
      if ($urandom_range(0, 15) == 0)
        item = $urandom_range(0, 1) ? '1 : '0;
      else
        item = $urandom;
      send_request(act, item, prio);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_INSERT;
    in_ch.in_item     = '0;
    in_ch.in_priority = '0;
    pq_count          = 0;
    error_count       = 0;
    quiet_cycles      = 0;
    hold_cycles       = 0;
    bursts_on         = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_extremes();
    test_tie_order();
    test_fill_under_stall();
    test_pause_and_drain();
    test_random_mix(600);
    // final stretch at full rate
    bursts_on = 1'b0;
    test_random_mix(160);
    wait_for_results();
    repeat (10) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("min_priority_queue verification clean");
    end else begin
      $display("min_priority_queue verification failed");
    end
    $finish;
  end

endmodule
